FILE: rtl/core/mofn_pkg.sv
// Shared constants for the median-of-N network unit: window mode codes,
// sample count and the compare-exchange step tables. No dependencies.
`default_nettype none

package mofn_pkg;

    // Samples carried by one input item
    localparam int NUM_SAMPLES = 9;

    // Width of a slot index into the sample array
    localparam int SLOT_W = $clog2(NUM_SAMPLES);

    // Window size register
    localparam int MODE_W = 2;
    typedef logic [MODE_W-1:0] window_mode_t;

    localparam window_mode_t MODE_WIN3 = 2'd0;
    localparam window_mode_t MODE_WIN5 = 2'd1;
    localparam window_mode_t MODE_WIN7 = 2'd2;
    localparam window_mode_t MODE_WIN9 = 2'd3;

    // One compare-exchange: slot lo takes the smaller, slot hi the larger
    typedef struct packed {
        logic [SLOT_W-1:0] lo;
        logic [SLOT_W-1:0] hi;
    } cx_pair_t;

    localparam int NET3_STEPS = 3;
    localparam int NET5_STEPS = 7;
    localparam int NET7_STEPS = 13;
    localparam int NET9_STEPS = 19;

    localparam cx_pair_t NET3 [NET3_STEPS] = '{
        '{4'd0, 4'd1}, '{4'd1, 4'd2}, '{4'd0, 4'd1}
    };

    localparam cx_pair_t NET5 [NET5_STEPS] = '{
        '{4'd0, 4'd1}, '{4'd3, 4'd4}, '{4'd0, 4'd3}, '{4'd1, 4'd4},
        '{4'd1, 4'd2}, '{4'd2, 4'd3}, '{4'd1, 4'd2}
    };

    localparam cx_pair_t NET7 [NET7_STEPS] = '{
        '{4'd0, 4'd5}, '{4'd0, 4'd3}, '{4'd1, 4'd6}, '{4'd2, 4'd4},
        '{4'd0, 4'd1}, '{4'd3, 4'd5}, '{4'd2, 4'd6}, '{4'd2, 4'd3},
        '{4'd3, 4'd6}, '{4'd4, 4'd5}, '{4'd1, 4'd4}, '{4'd1, 4'd3},
        '{4'd3, 4'd4}
    };

    // Last steps run with lo above hi on purpose: they keep the middle in slot 4
    localparam cx_pair_t NET9 [NET9_STEPS] = '{
        '{4'd1, 4'd2}, '{4'd4, 4'd5}, '{4'd7, 4'd8}, '{4'd0, 4'd1},
        '{4'd3, 4'd4}, '{4'd6, 4'd7}, '{4'd1, 4'd2}, '{4'd4, 4'd5},
        '{4'd7, 4'd8}, '{4'd0, 4'd3}, '{4'd5, 4'd8}, '{4'd4, 4'd7},
        '{4'd3, 4'd6}, '{4'd1, 4'd4}, '{4'd2, 4'd5}, '{4'd4, 4'd7},
        '{4'd4, 4'd2}, '{4'd6, 4'd4}, '{4'd4, 4'd2}
    };

    // Middle slot of each network
    localparam logic [SLOT_W-1:0] MID3 = 4'd1;
    localparam logic [SLOT_W-1:0] MID5 = 4'd2;
    localparam logic [SLOT_W-1:0] MID7 = 4'd3;
    localparam logic [SLOT_W-1:0] MID9 = 4'd4;

endpackage

`default_nettype wire

FILE: rtl/core/mofn_median_net.sv
// Combinational median networks for windows of 3, 5, 7 and 9 samples.
// Depends on mofn_pkg for the step tables and window mode codes.
`default_nettype none

module mofn_median_net #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0] samples_i [mofn_pkg::NUM_SAMPLES],
    input  wire mofn_pkg::window_mode_t         window_mode_i,
    output logic signed [SAMPLE_WIDTH-1:0]      median_o
);

    typedef logic signed [SAMPLE_WIDTH-1:0] smp_arr_t [mofn_pkg::NUM_SAMPLES];

    // One compare-exchange on a signed sample array
    function automatic smp_arr_t cx_step(input smp_arr_t s, input mofn_pkg::cx_pair_t p);
        smp_arr_t r;
        r = s;
        if (s[p.lo] > s[p.hi]) begin
            r[p.lo] = s[p.hi];
            r[p.hi] = s[p.lo];
        end
        return r;
    endfunction

    smp_arr_t s3;
    smp_arr_t s5;
    smp_arr_t s7;
    smp_arr_t s9;

    // Run each network over the item
    always_comb begin
        s3 = samples_i;
        for (int k = 0; k < mofn_pkg::NET3_STEPS; k++) begin
            s3 = cx_step(s3, mofn_pkg::NET3[k]);
        end
    end

    always_comb begin
        s5 = samples_i;
        for (int k = 0; k < mofn_pkg::NET5_STEPS; k++) begin
            s5 = cx_step(s5, mofn_pkg::NET5[k]);
        end
    end

    always_comb begin
        s7 = samples_i;
        for (int k = 0; k < mofn_pkg::NET7_STEPS; k++) begin
            s7 = cx_step(s7, mofn_pkg::NET7[k]);
        end
    end

    always_comb begin
        s9 = samples_i;
        for (int k = 0; k < mofn_pkg::NET9_STEPS; k++) begin
            s9 = cx_step(s9, mofn_pkg::NET9[k]);
        end
    end

    // Pick the middle slot of the selected window
    always_comb begin
        case (window_mode_i)
            mofn_pkg::MODE_WIN3: median_o = s3[mofn_pkg::MID3];
            mofn_pkg::MODE_WIN5: median_o = s5[mofn_pkg::MID5];
            mofn_pkg::MODE_WIN7: median_o = s7[mofn_pkg::MID7];
            default:             median_o = s9[mofn_pkg::MID9];
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/median_of_n_network_unit.sv
// Median-of-N unit: each item of nine signed samples returns the median of
// the first 3, 5, 7 or 9 samples, chosen by the window_mode register
// (cfg_wr_data: 0 -> 3, 1 -> 5, 2 -> 7, 3 -> 9). The unit takes one item per
// clock cycle when the output is not back-pressured. Each accepted item is held
// in the input register, then goes through the compare-exchange network into
// the result register. The network for nine samples (19 exchanges, nine levels
// deep) sets the clock period. Both stages hold under back-pressure.
// Depends on mofn_pkg and mofn_median_net.
`default_nettype none

module median_of_n_network_unit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_wr_en,
    input  wire mofn_pkg::window_mode_t         cfg_wr_data,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_0,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_1,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_2,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_3,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_4,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_5,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_6,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_7,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample_8,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_median_value
);

    mofn_pkg::window_mode_t window_mode_reg;

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] in_samples_reg [mofn_pkg::NUM_SAMPLES];
    mofn_pkg::window_mode_t         in_mode_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_median_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_next;

    logic in_accept;
    logic advance;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_mode_reg <= mofn_pkg::MODE_WIN3;
        end else if (cfg_wr_en) begin
            window_mode_reg <= cfg_wr_data;
        end
    end

    // Handshake: advance when the result stage is free or drains this cycle
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign in_accept = s_valid && s_ready;

    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item and the window it runs under
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_samples_reg[0] <= s_sample_0;
            in_samples_reg[1] <= s_sample_1;
            in_samples_reg[2] <= s_sample_2;
            in_samples_reg[3] <= s_sample_3;
            in_samples_reg[4] <= s_sample_4;
            in_samples_reg[5] <= s_sample_5;
            in_samples_reg[6] <= s_sample_6;
            in_samples_reg[7] <= s_sample_7;
            in_samples_reg[8] <= s_sample_8;
            in_mode_reg       <= window_mode_reg;
        end
    end

    mofn_median_net #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_net (
        .samples_i     (in_samples_reg),
        .window_mode_i (in_mode_reg),
        .median_o      (median_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_median_reg <= median_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_median_value = out_median_reg;

`ifndef SYNTHESIS
    // Reset empties both stages
    assert property (@(posedge aclk) !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // A held item moves into the result stage once it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("item lost between stages");

    // A blocked input stage keeps its item: still valid, with sample 4 and its window mode stable
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_samples_reg[4])
            && $stable(in_mode_reg))
        else $error("input stage changed while blocked");

    // The three-sample median is one of the window samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance && in_mode_reg == mofn_pkg::MODE_WIN3 |=>
            out_median_reg == $past(in_samples_reg[0])
            || out_median_reg == $past(in_samples_reg[1])
            || out_median_reg == $past(in_samples_reg[2]))
        else $error("window-3 median not among its samples");
`endif

endmodule

`default_nettype wire
